>>> rtl/core/pra_pkg.sv
// shared types and constants for the piecewise rate age model
// no dependencies; used by pra_search_cell and piecewise_rate_age_model_top
package pra_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int DEPTH_W       = 32;
    localparam int AGE_W         = 48;
    localparam int CFG_IDX_W     = 1;

    localparam logic [DEPTH_W-1:0] SPACING_RESET = 32'h0001_0000;
    localparam logic [AGE_W-1:0]   Q48_MAX       = {1'b0, {(AGE_W-1){1'b1}}};
    localparam logic [AGE_W-1:0]   Q48_MIN       = {1'b1, {(AGE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_NODE_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_AGE      = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_AGE_VALID = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_QUERY
    } t_state;

    // control travelling with a search item from cell to cell
    typedef struct packed {
        logic valid;
        logic live;
    } t_probe_ctl;

endpackage

>>> rtl/core/pra_search_cell.sv
// one step of the binary search: settles the previous probe, picks the next
// midpoint and reads its own copy of the node depths; depends on pra_pkg
module pra_search_cell #(
    parameter int   MAX_NODES = pra_pkg::MAX_NODES_DEF,
    localparam int  AW        = $clog2(MAX_NODES),
    localparam int  CW        = $clog2(MAX_NODES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [pra_pkg::DEPTH_W-1:0]  i_wr_depth,
    input  pra_pkg::t_probe_ctl          i_ctl,
    input  logic [CW-1:0]                i_lo,
    input  logic [CW-1:0]                i_hp,
    input  logic [AW-1:0]                i_mid,
    input  logic [pra_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [pra_pkg::DEPTH_W-1:0]  i_query,
    output pra_pkg::t_probe_ctl          o_ctl,
    output logic [CW-1:0]                o_lo,
    output logic [CW-1:0]                o_hp,
    output logic [AW-1:0]                o_mid,
    output logic [pra_pkg::DEPTH_W-1:0]  o_depth,
    output logic [pra_pkg::DEPTH_W-1:0]  o_query
);

    logic [pra_pkg::DEPTH_W-1:0] mem_depth [MAX_NODES];

    pra_pkg::t_probe_ctl          r_ctl;
    logic [CW-1:0]                r_lo;
    logic [CW-1:0]                r_hp;
    logic [AW-1:0]                r_mid;
    logic [pra_pkg::DEPTH_W-1:0]  r_depth;
    logic [pra_pkg::DEPTH_W-1:0]  r_query;

    logic          below;
    logic [CW-1:0] lo_u;
    logic [CW-1:0] hp_u;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] n_mid;
    logic          n_live;

    // hp is high + 1, so the window is empty when lo reaches hp
    always_comb begin
        below = (i_depth < i_query);
        lo_u  = i_lo;
        hp_u  = i_hp;
        if (i_ctl.live) begin
            if (below) begin
                lo_u = CW'(i_mid) + CW'(1);
            end else begin
                hp_u = CW'(i_mid);
            end
        end
        n_live  = (lo_u < hp_u);
        mid_sum = {1'b0, lo_u} + {1'b0, hp_u} - (CW+1)'(1);
        n_mid   = mid_sum[AW:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
            r_ctl.live  <= i_ctl.valid & n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= lo_u;
        r_hp    <= hp_u;
        r_mid   <= n_mid;
        r_query <= i_query;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_depth[i_wr_addr] <= i_wr_depth;
        end
        r_depth <= mem_depth[n_mid];
    end

    assign o_ctl   = r_ctl;
    assign o_lo    = r_lo;
    assign o_hp    = r_hp;
    assign o_mid   = r_mid;
    assign o_depth = r_depth;
    assign o_query = r_query;

endmodule

>>> rtl/core/piecewise_rate_age_model_top.sv
// piecewise linear age model: node table, chain of binary search cells,
// interpolation and saturating Q32.16 arithmetic; depends on pra_pkg, pra_search_cell
//
//   channel   direction  handshake              payload
//   command   in         start & !busy          i_action, i_node_depth, i_node_rate,
//                                               i_query_depth
//   result    out        o_done, one cycle      o_status, o_age
//   config    in         i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// clear, full load, empty query and unused action: result in the cycle after accept
// load: spacing multiply registered at accept, then running sum add, then result
// query: search cells in order, then node read, rate multiply, prefix add, age
//   subtract, each registered before the result
// one item at a time; busy is high during a load or search; results cannot be stalled
// reset clears node count, running sum, state and flags; node stores need no clearing
module piecewise_rate_age_model_top #(
    parameter int MAX_NODES = pra_pkg::MAX_NODES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_action,
    input  logic [pra_pkg::DEPTH_W-1:0]     i_node_depth,
    input  logic [pra_pkg::DEPTH_W-1:0]     i_node_rate,
    input  logic [pra_pkg::DEPTH_W-1:0]     i_query_depth,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic signed [pra_pkg::AGE_W-1:0] o_age,
    input  logic                            i_cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pra_pkg::AGE_W-1:0]       i_cfg_wdata
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int NSTEP = CW;
    localparam int DW    = pra_pkg::DEPTH_W;
    localparam int GW    = pra_pkg::AGE_W;

    pra_pkg::t_state r_state, n_state;

    logic [DW-1:0]        r_spacing;
    logic signed [GW-1:0] r_top_age;
    logic [CW-1:0]        r_count, n_count;
    logic [GW-1:0]        r_sum, n_sum;
    logic [2*DW-1:0]      r_prod;

    logic                 r_done, n_done;
    logic [1:0]           r_status, n_status;
    logic [GW-1:0]        r_age, n_age;

    logic accept;
    logic store_we;
    logic launch;

    // node table read after the search
    logic [DW-1:0] mem_depth  [MAX_NODES];
    logic [DW-1:0] mem_rate   [MAX_NODES];
    logic [GW-1:0] mem_prefix [MAX_NODES];

    // search chain
    pra_pkg::t_probe_ctl c_ctl   [NSTEP+1];
    logic [CW-1:0]       c_lo    [NSTEP+1];
    logic [CW-1:0]       c_hp    [NSTEP+1];
    logic [AW-1:0]       c_mid   [NSTEP+1];
    logic [DW-1:0]       c_depth [NSTEP+1];
    logic [DW-1:0]       c_query [NSTEP+1];

    logic          last_below;
    logic [CW-1:0] lo_f;
    logic [CW-1:0] lo_m1;
    logic [AW-1:0] pick;

    logic          r_fetch_v;
    logic [DW-1:0] r_f_depth;
    logic [DW-1:0] r_f_rate;
    logic [GW-1:0] r_f_prefix;
    logic [DW-1:0] r_f_query;

    logic          ge;
    logic [DW-1:0] gap;

    logic            r_mul_v;
    logic [2*DW-1:0] r_mag;
    logic            r_ge;
    logic [GW-1:0]   r_m_prefix;

    logic [2*DW:0]   mag_up;
    logic [GW:0]     tmag;
    logic [GW+1:0]   term;
    logic [GW+1:0]   cum_wide;
    logic [GW-1:0]   cum_sat;

    logic          r_cum_v;
    logic [GW-1:0] r_cum;

    logic [GW:0]   age_wide;
    logic [GW-1:0] age_sat;

    logic [GW-1:0] step;
    logic [GW:0]   load_wide;
    logic [GW-1:0] load_sum;

    assign busy   = (r_state != pra_pkg::S_IDLE);
    assign accept = start & ~busy;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= pra_pkg::SPACING_RESET;
            r_top_age <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pra_pkg::REG_NODE_SPACING: r_spacing <= i_cfg_wdata[DW-1:0];
                pra_pkg::REG_TOP_AGE:      r_top_age <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // load path: saturating running sum of rate times spacing
    always_comb begin
        step = r_prod[2*DW-1:16];
        if (step[GW-1]) begin
            step = pra_pkg::Q48_MAX;
        end
        load_wide = {1'b0, r_sum} + {1'b0, step};
        load_sum  = (load_wide[GW:GW-1] != 2'b00) ? pra_pkg::Q48_MAX : load_wide[GW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= (2*DW)'(i_node_rate) * (2*DW)'(r_spacing);
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem_depth[r_count[AW-1:0]]  <= i_node_depth;
            mem_rate[r_count[AW-1:0]]   <= i_node_rate;
            mem_prefix[r_count[AW-1:0]] <= r_sum;
        end
    end

    // search chain, one cell per step
    assign c_ctl[0].valid = launch;
    assign c_ctl[0].live  = 1'b0;
    assign c_lo[0]        = '0;
    assign c_hp[0]        = r_count;
    assign c_mid[0]       = '0;
    assign c_depth[0]     = '0;
    assign c_query[0]     = i_query_depth;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        pra_search_cell #(
            .MAX_NODES (MAX_NODES)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (store_we),
            .i_wr_addr  (r_count[AW-1:0]),
            .i_wr_depth (i_node_depth),
            .i_ctl      (c_ctl[g]),
            .i_lo       (c_lo[g]),
            .i_hp       (c_hp[g]),
            .i_mid      (c_mid[g]),
            .i_depth    (c_depth[g]),
            .i_query    (c_query[g]),
            .o_ctl      (c_ctl[g+1]),
            .o_lo       (c_lo[g+1]),
            .o_hp       (c_hp[g+1]),
            .o_mid      (c_mid[g+1]),
            .o_depth    (c_depth[g+1]),
            .o_query    (c_query[g+1])
        );
    end

    // settle the last probe, then step back one node (clamped to node 0)
    always_comb begin
        last_below = (c_depth[NSTEP] < c_query[NSTEP]);
        lo_f       = c_lo[NSTEP];
        if (c_ctl[NSTEP].live && last_below) begin
            lo_f = CW'(c_mid[NSTEP]) + CW'(1);
        end
        lo_m1 = lo_f - CW'(1);
        pick  = (lo_f != '0) ? lo_m1[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_v <= 1'b0;
            r_mul_v   <= 1'b0;
            r_cum_v   <= 1'b0;
        end else begin
            r_fetch_v <= c_ctl[NSTEP].valid;
            r_mul_v   <= r_fetch_v;
            r_cum_v   <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_depth  <= mem_depth[pick];
        r_f_rate   <= mem_rate[pick];
        r_f_prefix <= mem_prefix[pick];
        r_f_query  <= c_query[NSTEP];
    end

    always_comb begin
        ge  = (r_f_query >= r_f_depth);
        gap = ge ? (r_f_query - r_f_depth) : (r_f_depth - r_f_query);
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= (2*DW)'(r_f_rate) * (2*DW)'(gap);
        r_ge       <= ge;
        r_m_prefix <= r_f_prefix;
    end

    // below the node the term rounds toward minus infinity
    always_comb begin
        mag_up = {1'b0, r_mag} + (2*DW+1)'(16'hFFFF);
        if (r_ge) begin
            tmag = {1'b0, r_mag[2*DW-1:16]};
            term = {1'b0, tmag};
        end else begin
            tmag = mag_up[2*DW:16];
            term = -{1'b0, tmag};
        end
        cum_wide = term + {{2{r_m_prefix[GW-1]}}, r_m_prefix};
        if (cum_wide[GW+1:GW-1] == 3'b000 || cum_wide[GW+1:GW-1] == 3'b111) begin
            cum_sat = cum_wide[GW-1:0];
        end else if (cum_wide[GW+1]) begin
            cum_sat = pra_pkg::Q48_MIN;
        end else begin
            cum_sat = pra_pkg::Q48_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum <= cum_sat;
    end

    always_comb begin
        age_wide = {r_top_age[GW-1], r_top_age} - {r_cum[GW-1], r_cum};
        if (age_wide[GW] == age_wide[GW-1]) begin
            age_sat = age_wide[GW-1:0];
        end else if (age_wide[GW]) begin
            age_sat = pra_pkg::Q48_MIN;
        end else begin
            age_sat = pra_pkg::Q48_MAX;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pra_pkg::S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_age    <= n_age;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sum    = r_sum;
        n_done   = 1'b0;
        n_status = pra_pkg::ST_ACCEPTED;
        n_age    = '0;
        store_we = 1'b0;
        launch   = 1'b0;
        case (r_state)
            pra_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        pra_pkg::ACT_CLEAR: begin
                            n_done  = 1'b1;
                            n_count = '0;
                            n_sum   = '0;
                        end
                        pra_pkg::ACT_LOAD: begin
                            if (r_count >= CW'(MAX_NODES)) begin
                                n_done   = 1'b1;
                                n_status = pra_pkg::ST_FULL;
                            end else begin
                                store_we = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_state  = pra_pkg::S_LOAD;
                            end
                        end
                        pra_pkg::ACT_QUERY: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = pra_pkg::ST_EMPTY;
                            end else begin
                                launch  = 1'b1;
                                n_state = pra_pkg::S_QUERY;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            pra_pkg::S_LOAD: begin
                n_sum   = load_sum;
                n_done  = 1'b1;
                n_state = pra_pkg::S_IDLE;
            end
            pra_pkg::S_QUERY: begin
                if (r_cum_v) begin
                    n_done   = 1'b1;
                    n_status = pra_pkg::ST_AGE_VALID;
                    n_age    = age_sat;
                    n_state  = pra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pra_pkg::S_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_age    = r_age;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("node count beyond table size");

    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == pra_pkg::ACT_QUERY && r_count == '0)
        |=> (o_done && o_status == pra_pkg::ST_EMPTY))
        else $error("query on empty table not answered with empty status");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == pra_pkg::ACT_LOAD && r_count < CW'(MAX_NODES))
        |=> (r_count == $past(r_count) + CW'(1) && r_state == pra_pkg::S_LOAD))
        else $error("load did not advance node count");

    a_chain_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ctl[NSTEP].valid || r_fetch_v || r_mul_v || r_cum_v)
        |-> r_state == pra_pkg::S_QUERY)
        else $error("search item in flight outside query state");

    a_age_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != pra_pkg::ST_AGE_VALID) |-> o_age == '0)
        else $error("age nonzero on a non-age result");

endmodule
